// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the scaler RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define LBS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scaler assertion failed");

// Next-cycle implication, switched off while reset is held.
`define LBS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scaler assertion failed");

`endif

// ===== rtl/lbs_pkg.sv =====
// ----------------------------------------------------------------------------
// lbs_pkg
// Sizes, reciprocal constants and shared types of the letterbox scaler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lbs_pkg;

    localparam int SRC_WIDTH  = 320;
    localparam int SRC_HEIGHT = 240;
    localparam int DST_WIDTH  = 960;
    localparam int DST_HEIGHT = 544;

    localparam int BOX_WIDTH  = 720;
    localparam int BOX_HEIGHT = 540;
    localparam int BOX_LEFT   = 120;

    localparam int SX_W  = 9;
    localparam int SY_W  = 8;
    localparam int RGB_W = 24;
    localparam int OX_W  = 10;
    localparam int OY_W  = 10;
    localparam int PIX_W = 16;

    // Wide enough for any panel size and for the right edge of the viewport.
    localparam int CMP_W = 12;

    localparam int COORD_W = (OX_W > OY_W) ? OX_W : OY_W;
    localparam int SRC_MAX = (SRC_WIDTH > SRC_HEIGHT) ? SRC_WIDTH : SRC_HEIGHT;
    localparam int P_W     = COORD_W + $clog2(SRC_MAX + 1);

    localparam int DIV_A   = (DST_WIDTH > DST_HEIGHT) ? DST_WIDTH : DST_HEIGHT;
    localparam int DIV_B   = (BOX_WIDTH > BOX_HEIGHT) ? BOX_WIDTH : BOX_HEIGHT;
    localparam int DIV_MAX = (DIV_A > DIV_B) ? DIV_A : DIV_B;
    localparam int L_W     = $clog2(DIV_MAX);

    // A numerator below 2**P_W times the rounded-up reciprocal, shifted right
    // by SHIFT, gives the exact floor quotient for every divisor up to 2**L_W.
    localparam int SHIFT = P_W + L_W;
    localparam int M_W   = SHIFT - 3;
    localparam int PM_W  = P_W + M_W;

    localparam logic [M_W-1:0] M_COL_WIDE = M_W'(((64'd1 << SHIFT) +
        64'(DST_WIDTH) - 64'd1) / 64'(DST_WIDTH));
    localparam logic [M_W-1:0] M_ROW_WIDE = M_W'(((64'd1 << SHIFT) +
        64'(DST_HEIGHT) - 64'd1) / 64'(DST_HEIGHT));
    localparam logic [M_W-1:0] M_COL_BOX = M_W'(((64'd1 << SHIFT) +
        64'(BOX_WIDTH) - 64'd1) / 64'(BOX_WIDTH));
    localparam logic [M_W-1:0] M_ROW_BOX = M_W'(((64'd1 << SHIFT) +
        64'(BOX_HEIGHT) - 64'd1) / 64'(BOX_HEIGHT));

    localparam int COL_W  = $clog2(SRC_WIDTH);
    localparam int ROW_W  = $clog2(SRC_HEIGHT);
    localparam int DEPTH  = SRC_WIDTH * SRC_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam int QDEPTH = 4;
    localparam int QA_W   = $clog2(QDEPTH);
    localparam int QC_W   = $clog2(QDEPTH + 1);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef enum logic [1:0] {
        KIND_WRITE,
        KIND_READ,
        KIND_BLACK
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  pix;
    } t_item;

    typedef struct packed {
        logic            empty;
        logic [QC_W-1:0] count;
    } t_q_status;

endpackage

`default_nettype wire

// ===== rtl/lbs_ram.sv =====
// ----------------------------------------------------------------------------
// lbs_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/lbs_front.sv =====
// ----------------------------------------------------------------------------
// lbs_front
// Takes commands, classifies them and works out the frame store address.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lbs_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_op,
    input  logic [lbs_pkg::SX_W-1:0]  i_src_x,
    input  logic [lbs_pkg::SY_W-1:0]  i_src_y,
    input  logic [lbs_pkg::RGB_W-1:0] i_pixel_rgb,
    input  logic [lbs_pkg::OX_W-1:0]  i_out_x,
    input  logic [lbs_pkg::OY_W-1:0]  i_out_y,
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_wdata,
    input  lbs_pkg::t_q_status      i_q_status,
    output logic                    o_push,
    output lbs_pkg::t_item          o_push_item
);
    import lbs_pkg::*;

    localparam int IF_W = QC_W + 1;

    logic r_four_three;
    logic r_s0_valid, n_s0_valid;
    logic r_s1_valid, n_s1_valid;

    t_kind            r_s0_kind;
    logic             r_s0_box;
    logic [P_W-1:0]   r_s0_num_col;
    logic [P_W-1:0]   r_s0_num_row;
    logic [PIX_W-1:0] r_s0_pix;

    t_kind             r_s1_kind;
    logic [COL_W-1:0]  r_s1_col;
    logic [ROW_W-1:0]  r_s1_row;
    logic [PIX_W-1:0]  r_s1_pix;

    logic [CMP_W-1:0] dx, dy, sx, sy, col_coord;
    logic             accept, wr_ok, off_panel, off_box, keep;
    t_kind            kind;
    logic [P_W-1:0]   num_col, num_row;
    logic [PIX_W-1:0] pix565;
    logic [IF_W-1:0]  in_flight;

    logic [M_W-1:0]   m_col, m_row;
    logic [PM_W-1:0]  prod_col, prod_row;
    logic [COL_W-1:0] s1_col;
    logic [ROW_W-1:0] s1_row;

    // Items in the address pipeline plus those waiting in the queue.
    assign in_flight = IF_W'(r_s0_valid) + IF_W'(r_s1_valid) + IF_W'(i_q_status.count);
    assign busy      = in_flight >= IF_W'(QDEPTH);
    assign accept    = start && !busy;

    assign dx = CMP_W'(i_out_x);
    assign dy = CMP_W'(i_out_y);
    assign sx = CMP_W'(i_src_x);
    assign sy = CMP_W'(i_src_y);

    assign pix565 = {i_pixel_rgb[23:19], i_pixel_rgb[15:10], i_pixel_rgb[7:3]};

    always_comb begin
        wr_ok     = (sx < CMP_W'(SRC_WIDTH)) && (sy < CMP_W'(SRC_HEIGHT));
        off_panel = (dx >= CMP_W'(DST_WIDTH)) || (dy >= CMP_W'(DST_HEIGHT));
        off_box   = (dy >= CMP_W'(BOX_HEIGHT)) || (dx < CMP_W'(BOX_LEFT)) ||
                    (dx >= CMP_W'(BOX_LEFT + BOX_WIDTH));
        col_coord = r_four_three ? (dx - CMP_W'(BOX_LEFT)) : dx;
        if (i_op == OP_WRITE) begin
            kind    = KIND_WRITE;
            keep    = wr_ok;
            num_col = P_W'(sx);
            num_row = P_W'(sy);
        end else begin
            kind    = (off_panel || (r_four_three && off_box)) ? KIND_BLACK : KIND_READ;
            keep    = 1'b1;
            num_col = P_W'(col_coord) * P_W'(SRC_WIDTH);
            num_row = P_W'(dy) * P_W'(SRC_HEIGHT);
        end
    end

    // Quotient by reciprocal; a write carries its coordinates straight through.
    always_comb begin
        m_col    = r_s0_box ? M_COL_BOX : M_COL_WIDE;
        m_row    = r_s0_box ? M_ROW_BOX : M_ROW_WIDE;
        prod_col = PM_W'(r_s0_num_col) * PM_W'(m_col);
        prod_row = PM_W'(r_s0_num_row) * PM_W'(m_row);
        if (r_s0_kind == KIND_WRITE) begin
            s1_col = COL_W'(r_s0_num_col);
            s1_row = ROW_W'(r_s0_num_row);
        end else begin
            s1_col = COL_W'(prod_col >> SHIFT);
            s1_row = ROW_W'(prod_row >> SHIFT);
        end
    end

    always_comb begin
        n_s0_valid = accept && keep;
        n_s1_valid = r_s0_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_four_three <= 1'b0;
            r_s0_valid   <= 1'b0;
            r_s1_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_four_three <= i_cfg_wdata;
            end
            r_s0_valid <= n_s0_valid;
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s0_kind    <= kind;
            r_s0_box     <= r_four_three;
            r_s0_num_col <= num_col;
            r_s0_num_row <= num_row;
            r_s0_pix     <= pix565;
        end
        r_s1_kind <= r_s0_kind;
        r_s1_col  <= s1_col;
        r_s1_row  <= s1_row;
        r_s1_pix  <= r_s0_pix;
    end

    assign o_push           = r_s1_valid;
    assign o_push_item.kind = r_s1_kind;
    assign o_push_item.addr = ADDR_W'(r_s1_row) * ADDR_W'(SRC_WIDTH) + ADDR_W'(r_s1_col);
    assign o_push_item.pix  = r_s1_pix;

    `LBS_ASSERT_NXT(a_read_enters_pipe, i_clk, i_rst_n, accept && (i_op == OP_READ),
        r_s0_valid && (r_s0_kind != KIND_WRITE))

endmodule

`default_nettype wire

// ===== rtl/lbs_queue.sv =====
// ----------------------------------------------------------------------------
// lbs_queue
// Short FIFO between the address pipeline and the frame store side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lbs_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  lbs_pkg::t_item     i_item,
    input  logic               i_pop,
    output lbs_pkg::t_item     o_item,
    output lbs_pkg::t_q_status o_status
);
    import lbs_pkg::*;

    t_item            r_mem [QDEPTH];
    logic [QA_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QA_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QC_W-1:0]  r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QA_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QA_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_item         = r_mem[r_rd_ptr];
    assign o_status.empty = (r_count == '0);
    assign o_status.count = r_count;

    `LBS_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push && !i_pop,
        r_count != QC_W'(QDEPTH))
    `LBS_ASSERT_NXT(a_count_tracks, i_clk, i_rst_n, i_push && !i_pop,
        r_count == QC_W'($past(r_count) + 1'b1))

endmodule

`default_nettype wire

// ===== rtl/lbs_back.sv =====
// ----------------------------------------------------------------------------
// lbs_back
// Drains the queue into the frame store and returns display pixels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lbs_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  lbs_pkg::t_q_status        i_q_status,
    input  lbs_pkg::t_item            i_item,
    output logic                      o_pop,
    output logic                      o_valid,
    output logic [lbs_pkg::PIX_W-1:0] o_display_pixel
);
    import lbs_pkg::*;

    logic             ram_we, ram_re;
    logic [PIX_W-1:0] ram_rdata;

    logic r_b1_valid, n_b1_valid;
    logic r_b1_black;
    logic r_out_valid, n_out_valid;
    logic [PIX_W-1:0] r_out_pixel;

    // At most one frame store access per cycle, so the queue never has to wait.
    assign o_pop = !i_q_status.empty;

    always_comb begin
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        n_b1_valid = 1'b0;
        if (o_pop) begin
            case (i_item.kind)
                KIND_WRITE: ram_we = 1'b1;
                KIND_READ: begin
                    ram_re     = 1'b1;
                    n_b1_valid = 1'b1;
                end
                KIND_BLACK: n_b1_valid = 1'b1;
                default: n_b1_valid = 1'b0;
            endcase
        end
        n_out_valid = r_b1_valid;
    end

    lbs_ram #(
        .WIDTH(PIX_W),
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(i_item.addr),
        .i_wdata(i_item.pix),
        .i_re   (ram_re),
        .i_raddr(i_item.addr),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_b1_valid  <= n_b1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b1_black  <= (i_item.kind == KIND_BLACK);
        r_out_pixel <= r_b1_black ? '0 : ram_rdata;
    end

    assign o_valid         = r_out_valid;
    assign o_display_pixel = r_out_pixel;

    `LBS_ASSERT_NXT(a_write_gives_no_result, i_clk, i_rst_n, ram_we, !r_b1_valid)

endmodule

`default_nettype wire

// ===== rtl/letterbox_nearest_scaler_rgb565.sv =====
// ----------------------------------------------------------------------------
// letterbox_nearest_scaler_rgb565: frame store with nearest-neighbour scaler.
// Takes one command per cycle; a read passes address stages s0 and s1, the
// queue, b1 and the output register; the rate is set by the frame store.
// Reset selects the full panel and empties the pipeline and queue; the store
// is undefined until written. The receiver cannot stall, so busy stays low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module letterbox_nearest_scaler_rgb565 (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_op,
    input  logic [lbs_pkg::SX_W-1:0]  i_src_x,
    input  logic [lbs_pkg::SY_W-1:0]  i_src_y,
    input  logic [lbs_pkg::RGB_W-1:0] i_pixel_rgb,
    input  logic [lbs_pkg::OX_W-1:0]  i_out_x,
    input  logic [lbs_pkg::OY_W-1:0]  i_out_y,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_wdata,
    output logic                      o_valid,
    output logic [lbs_pkg::PIX_W-1:0] o_display_pixel
);
    import lbs_pkg::*;

    logic      push, pop;
    t_item     push_item, head_item;
    t_q_status q_status;

    lbs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_op       (i_op),
        .i_src_x    (i_src_x),
        .i_src_y    (i_src_y),
        .i_pixel_rgb(i_pixel_rgb),
        .i_out_x    (i_out_x),
        .i_out_y    (i_out_y),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_q_status (q_status),
        .o_push     (push),
        .o_push_item(push_item)
    );

    lbs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_status(q_status)
    );

    lbs_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_status     (q_status),
        .i_item         (head_item),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .o_display_pixel(o_display_pixel)
    );

endmodule

`default_nettype wire
